>>> hdl/humidity_temp_frame_decoder_defines.svh
// Assertion macros shared by the checker of the humidity and temperature frame decoder.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define HTFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/htfd_pkg.sv
// Package with the types, constants and CRC function of the frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [15:0] ID_MASK   = 16'h083F;
  localparam logic [15:0] ID_MATCH  = 16'h0807;
  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN  = 14'd10000;
  localparam logic [13:0] HUM_MAX   = 14'd10000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_FAIL = 2'd1,
    STATUS_ID_FAIL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               emit;
    status_t            status;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        chip_id;
    logic               id_valid;
  } htfd_result_t;

  // One byte through the CRC-8, most significant bit first, no final XOR.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/htfd_parse.sv
// Byte tracker of the frame decoder: position, CRC check, word capture and scaling.
`timescale 1ns / 1ps
`default_nettype none
module htfd_parse
  import htfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic         frame_kind,
  input  wire logic [7:0]   data_byte,
  input  wire logic         frame_start,
  output htfd_result_t      res
);

  logic [2:0]         byte_position, byte_position_next;
  logic [7:0]         running_crc, running_crc_next;
  logic               crc_failed, crc_failed_next;
  logic [7:0]         high_byte_hold;
  logic [15:0]        first_word_hold;
  logic [15:0]        second_word_hold;
  logic signed [14:0] temp_hold;

  logic               restart;
  logic [2:0]         pos;
  logic [7:0]         crc_cur;
  logic               fail_cur;
  logic               fail_now;
  logic [7:0]         crc_fed;
  logic [15:0]        word;
  logic               last_byte;
  logic [30:0]        temp_prod;
  logic [15:0]        temp_value;
  logic [29:0]        hum_prod;
  logic [13:0]        hum_value;
  logic               id_match;

  // A start flag, or a position past the end of the current frame kind, restarts.
  assign restart  = frame_start || (frame_kind ? (byte_position >= 3'd3)
                                               : (byte_position >= 3'd6));
  assign pos      = restart ? 3'd0 : byte_position;
  assign crc_cur  = restart ? CRC_INIT : running_crc;
  assign fail_cur = restart ? 1'b0 : crc_failed;
  assign crc_fed  = crc8_feed(crc_cur, data_byte);
  assign word     = {high_byte_hold, data_byte};
  assign fail_now = fail_cur || (crc_cur != data_byte);
  assign last_byte = (pos == 3'd5) || (frame_kind && (pos == 3'd2));

  // Temperature is scaled on the first CRC byte, humidity on the last one.
  assign temp_prod  = 31'(TEMP_SPAN) * 31'(first_word_hold);
  assign temp_value = {1'b0, temp_prod[30:16]} - TEMP_OFFSET;
  assign hum_prod   = 30'(HUM_SPAN) * 30'(second_word_hold);
  assign hum_value  = (hum_prod[29:16] > HUM_MAX) ? HUM_MAX : hum_prod[29:16];
  assign id_match   = (first_word_hold & ID_MASK) == ID_MATCH;

  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    crc_failed_next    = crc_failed;
    res                = '0;
    res.status         = STATUS_OK;
    case (pos)
      3'd0, 3'd3, 3'd1, 3'd4: begin
        running_crc_next   = crc_fed;
        crc_failed_next    = fail_cur;
        byte_position_next = pos + 3'd1;
      end
      3'd2, 3'd5: begin
        running_crc_next = CRC_INIT;
        if (last_byte) begin
          byte_position_next = 3'd0;
          crc_failed_next    = 1'b0;
          res.emit           = 1'b1;
          if (fail_now) begin
            res.status = STATUS_CRC_FAIL;
          end else if (frame_kind) begin
            res.status   = id_match ? STATUS_OK : STATUS_ID_FAIL;
            res.chip_id  = first_word_hold;
            res.id_valid = id_match;
          end else begin
            res.temperature_centi = temp_hold;
            res.humidity_centi    = hum_value;
          end
        end else begin
          byte_position_next = pos + 3'd1;
          crc_failed_next    = fail_now;
        end
      end
      default: begin
        byte_position_next = 3'd0;
        running_crc_next   = CRC_INIT;
        crc_failed_next    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      running_crc   <= CRC_INIT;
      crc_failed    <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      crc_failed    <= crc_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == 3'd0 || pos == 3'd3) begin
        high_byte_hold <= data_byte;
      end
      if (pos == 3'd1) begin
        first_word_hold <= word;
      end
      if (pos == 3'd4) begin
        second_word_hold <= word;
      end
      if (pos == 3'd2) begin
        temp_hold <= signed'(temp_value[14:0]);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/humidity_temp_frame_decoder.sv
// A result is registered and appears on the outputs in the cycle after its last byte is taken.
// Throughput: one byte per cycle; input stalls only while a waiting result is stalled.
// A measurement frame takes six bytes per result, an identity frame three.
// Reset (rst, synchronous): byte position to zero, CRC to 0xFF, error flag clear,
// frame kind back to measurement, and the output register empty.
`timescale 1ns / 1ps
`default_nettype none
module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               frame_start,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic signed [14:0]      temperature_centi,
  output logic [13:0]             humidity_centi,
  output logic [15:0]             chip_id,
  output logic                    id_valid
);

  // Frame kind register: 0 selects six-byte measurement frames, 1 selects
  // three-byte identity frames. It is sampled afresh on every byte.
  logic         frame_kind;
  logic         accept;
  logic         out_valid_next;
  htfd_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind <= 1'b0;
    end else if (cfg_write) begin
      frame_kind <= cfg_data;
    end
  end

  // The output register is free when it is empty or its item leaves this
  // cycle, so bytes keep flowing while a result is being taken.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // The byte tracker keeps the frame state and produces the finished result
  // in the same cycle as the final CRC byte; temperature and humidity each have their own multiply.
  htfd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_kind  (frame_kind),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .res         (res)
  );

  always_comb begin
    if (accept) begin
      out_valid_next = res.emit;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload is loaded only when a frame completes; otherwise it holds,
  // which keeps a stalled item steady on the outputs.
  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      status            <= res.status;
      temperature_centi <= res.temperature_centi;
      humidity_centi    <= res.humidity_centi;
      chip_id           <= res.chip_id;
      id_valid          <= res.id_valid;
    end
  end

endmodule
`default_nettype wire

>>> hdl/htfd_checker.sv
// Port-level checker of the frame decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_temp_frame_decoder_defines.svh"
module htfd_checker
  import htfd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic signed [14:0] temperature_centi,
  input wire logic [13:0]        humidity_centi,
  input wire logic [15:0]        chip_id,
  input wire logic               id_valid
);

  `HTFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(chip_id) && $stable(temperature_centi), "stalled result changed")
  `HTFD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a waiting result")
  `HTFD_ASSERT_NOW(a_crc_zero, out_valid && (status == STATUS_CRC_FAIL), (temperature_centi == 15'sd0) && (humidity_centi == 14'd0) && (chip_id == 16'd0) && !id_valid, "CRC error result not zeroed")
  `HTFD_ASSERT_NOW(a_id_match, out_valid && id_valid, (status == STATUS_OK) && ((chip_id & ID_MASK) == ID_MATCH), "identity flag without a matching word")
  `HTFD_ASSERT_NOW(a_hum_range, out_valid, humidity_centi <= HUM_MAX, "humidity above full scale")

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .status            (status),
  .temperature_centi (temperature_centi),
  .humidity_centi    (humidity_centi),
  .chip_id           (chip_id),
  .id_valid          (id_valid)
);
`default_nettype wire
